// File: rtl/core/mavf_pkg.sv
package mavf_pkg;

    localparam int MAX_WINDOW  = 256;
    localparam int SAMPLE_BITS = 16;
    localparam int WIN_BITS    = 9;
    localparam int SUM_BITS    = SAMPLE_BITS + 9;
    localparam int PTR_BITS    = $clog2(MAX_WINDOW);
    localparam int DIV_CNT_BITS = $clog2(SUM_BITS + 1);

    localparam logic [WIN_BITS-1:0] WINDOW_RESET = WIN_BITS'(8);

    // Smallest magnitude that no longer fits a positive sample
    localparam logic [SUM_BITS-1:0] MAG_LIMIT = SUM_BITS'(1) << (SAMPLE_BITS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV
    } mavf_state_t;

    typedef struct packed {
        logic                       start;
        logic signed [SUM_BITS-1:0] dividend;
        logic [WIN_BITS-1:0]        divisor;
    } mavf_div_req_t;

    typedef struct packed {
        logic                          done;
        logic signed [SAMPLE_BITS-1:0] quotient;
    } mavf_div_res_t;

    // Zero counts as one, anything beyond the history depth saturates
    function automatic logic [WIN_BITS-1:0] eff_window(input logic [WIN_BITS-1:0] ws);
        logic [WIN_BITS-1:0] w;
        if (ws == '0) begin
            w = WIN_BITS'(1);
        end else if (32'(ws) > MAX_WINDOW) begin
            w = WIN_BITS'(MAX_WINDOW);
        end else begin
            w = ws;
        end
        return w;
    endfunction

endpackage

// File: rtl/core/moving_average_filter_core.sv
// Channel    | Direction | Payload                               | Handshake
// s_ (input) | in        | tdata: sample; tuser: segment_start   | s_tvalid / s_tready
// m_ (result)| out       | tdata: average                        | m_tvalid / m_tready
// cfg_       | in        | window_size                           | cfg_wr_en, no wait
//
// Each request runs through these steps in order: accept it and issue the history
// read, update the window sum and write the sample back, the restoring divider
// (one quotient bit a cycle), and loading the result register. The divider
// takes the longest; no new request is accepted until the result is loaded.
// Reset is synchronous, active low; the history memory is not cleared and
// needs no sweep. A stalled result holds in the output register while the
// next request is accepted; the divider result waits until that register frees.
module moving_average_filter_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    // window_size
    input  logic                               cfg_wr_en,
    input  logic [mavf_pkg::WIN_BITS-1:0]      cfg_wr_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [15:0] sample
    input  logic [mavf_pkg::SAMPLE_BITS-1:0]   s_tdata,
    // [0] segment_start
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [15:0] average
    output logic [mavf_pkg::SAMPLE_BITS-1:0]   m_tdata
);

    mavf_pkg::mavf_state_t                 state_reg, state_next;
    logic [mavf_pkg::WIN_BITS-1:0]         window_size_reg;
    logic [mavf_pkg::PTR_BITS-1:0]         wp_reg, wp_next;
    logic signed [mavf_pkg::SUM_BITS-1:0]  sum_reg, sum_next;
    logic [mavf_pkg::WIN_BITS-1:0]         count_reg, count_next;
    logic [mavf_pkg::WIN_BITS-1:0]         win_reg, win_next;
    logic                                  warm_reg, warm_next;
    logic [mavf_pkg::SAMPLE_BITS-1:0]      sample_reg, sample_next;
    logic                                  m_valid_reg, m_valid_next;
    logic [mavf_pkg::SAMPLE_BITS-1:0]      m_data_reg, m_data_next;

    logic                                  accept;
    logic [mavf_pkg::WIN_BITS-1:0]         w_eff;
    logic [mavf_pkg::WIN_BITS-1:0]         base_count;
    logic                                  ram_rd_en;
    logic                                  ram_wr_en;
    logic [mavf_pkg::PTR_BITS-1:0]         ram_rd_addr;
    logic [mavf_pkg::SAMPLE_BITS-1:0]      ram_rd_data;
    logic signed [mavf_pkg::SUM_BITS-1:0]  add_term, sub_term;
    mavf_pkg::mavf_div_req_t               div_req;
    mavf_pkg::mavf_div_res_t               div_res;

    assign s_tready = (state_reg == mavf_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign w_eff      = mavf_pkg::eff_window(window_size_reg);
    assign base_count = s_tuser ? '0 : count_reg;

    // Oldest sample of the window sits w entries behind the write pointer
    assign ram_rd_en   = accept;
    assign ram_rd_addr = wp_reg - mavf_pkg::PTR_BITS'(w_eff);
    assign ram_wr_en   = (state_reg == mavf_pkg::ST_READ);

    mavf_ram #(
        .WIDTH (mavf_pkg::SAMPLE_BITS),
        .DEPTH (mavf_pkg::MAX_WINDOW)
    ) u_history (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (wp_reg),
        .wr_data (sample_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    mavf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .res     (div_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= mavf_pkg::ST_IDLE;
            window_size_reg <= mavf_pkg::WINDOW_RESET;
            wp_reg          <= '0;
            sum_reg         <= '0;
            count_reg       <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            sum_reg     <= sum_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                window_size_reg <= cfg_wr_data;
            end
        end
        win_reg    <= win_next;
        warm_reg   <= warm_next;
        sample_reg <= sample_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next   = state_reg;
        wp_next      = wp_reg;
        sum_next     = sum_reg;
        count_next   = count_reg;
        win_next     = win_reg;
        warm_next    = warm_reg;
        sample_next  = sample_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_tready;

        add_term = {{(mavf_pkg::SUM_BITS-mavf_pkg::SAMPLE_BITS){sample_reg[mavf_pkg::SAMPLE_BITS-1]}},
                    sample_reg};
        sub_term = warm_reg ? '0 :
                   {{(mavf_pkg::SUM_BITS-mavf_pkg::SAMPLE_BITS){ram_rd_data[mavf_pkg::SAMPLE_BITS-1]}},
                    ram_rd_data};

        div_req.start    = 1'b0;
        div_req.dividend = sum_reg + add_term - sub_term;
        div_req.divisor  = warm_reg ? (count_reg + 1'b1) : win_reg;

        unique case (state_reg)
            mavf_pkg::ST_IDLE: begin
                if (accept) begin
                    // Drop the running sum and count on a new segment
                    sample_next = s_tdata;
                    if (s_tuser) begin
                        sum_next = '0;
                    end
                    count_next = base_count;
                    win_next   = w_eff;
                    warm_next  = (base_count < w_eff);
                    state_next = mavf_pkg::ST_READ;
                end
            end
            mavf_pkg::ST_READ: begin
                // Old sample is in from the history; fold it out, write the new one
                sum_next = div_req.dividend;
                if (warm_reg) begin
                    count_next = count_reg + 1'b1;
                end
                wp_next       = wp_reg + 1'b1;
                div_req.start = 1'b1;
                state_next    = mavf_pkg::ST_DIV;
            end
            mavf_pkg::ST_DIV: begin
                // Hold the quotient until the result register is free
                if (div_res.done && (!m_valid_reg || m_tready)) begin
                    m_data_next  = div_res.quotient;
                    m_valid_next = 1'b1;
                    state_next   = mavf_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mavf_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_accept_reads: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == mavf_pkg::ST_READ))
        else $error("accepted request did not move on to the history read");

    a_ptr_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mavf_pkg::ST_READ) |=> (wp_reg == $past(wp_reg) + 1'b1))
        else $error("write pointer did not advance once per request");

    a_warm_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mavf_pkg::ST_READ && warm_reg) |=>
            (count_reg == $past(count_reg) + 1'b1))
        else $error("warm-up count did not grow");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mavf_pkg::ST_DIV && state_next == mavf_pkg::ST_IDLE) |=> m_tvalid)
        else $error("divider finished but no result was presented");
`endif

endmodule

// File: rtl/core/mavf_ram.sv
module mavf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/core/mavf_div.sv
module mavf_div (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  mavf_pkg::mavf_div_req_t req,
    output mavf_pkg::mavf_div_res_t res
);

    logic                                  busy_reg, busy_next;
    logic                                  done_reg, done_next;
    logic                                  neg_reg, neg_next;
    logic [mavf_pkg::DIV_CNT_BITS-1:0]     cnt_reg, cnt_next;
    logic [mavf_pkg::SUM_BITS-1:0]         quo_reg, quo_next;
    logic [mavf_pkg::WIN_BITS-1:0]         rem_reg, rem_next;
    logic [mavf_pkg::WIN_BITS-1:0]         dvs_reg, dvs_next;
    logic [mavf_pkg::WIN_BITS:0]           trial;
    logic [mavf_pkg::SUM_BITS-1:0]         neg_q;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        neg_reg <= neg_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    // One restoring step per cycle, magnitude only
    always_comb begin
        busy_next = busy_reg;
        done_next = done_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, quo_reg[mavf_pkg::SUM_BITS-1]};
        if (req.start) begin
            busy_next = 1'b1;
            done_next = 1'b0;
            neg_next  = req.dividend[mavf_pkg::SUM_BITS-1];
            quo_next  = req.dividend[mavf_pkg::SUM_BITS-1] ? (~req.dividend + 1'b1)
                                                            : req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = mavf_pkg::DIV_CNT_BITS'(mavf_pkg::SUM_BITS);
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = mavf_pkg::WIN_BITS'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[mavf_pkg::SUM_BITS-2:0], 1'b1};
            end else begin
                rem_next = trial[mavf_pkg::WIN_BITS-1:0];
                quo_next = {quo_reg[mavf_pkg::SUM_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == mavf_pkg::DIV_CNT_BITS'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Restore sign and saturate to the sample range
    always_comb begin
        neg_q    = ~quo_reg + 1'b1;
        res.done = done_reg;
        if (neg_reg) begin
            if (quo_reg > mavf_pkg::MAG_LIMIT) begin
                res.quotient = {1'b1, {(mavf_pkg::SAMPLE_BITS-1){1'b0}}};
            end else begin
                res.quotient = neg_q[mavf_pkg::SAMPLE_BITS-1:0];
            end
        end else begin
            if (quo_reg >= mavf_pkg::MAG_LIMIT) begin
                res.quotient = {1'b0, {(mavf_pkg::SAMPLE_BITS-1){1'b1}}};
            end else begin
                res.quotient = quo_reg[mavf_pkg::SAMPLE_BITS-1:0];
            end
        end
    end

endmodule
